// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL. Each use sits on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tetration_modulo: assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define TM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tetration_modulo: assertion failed");

`endif

// File: sv/tm_pkg.sv
package tm_pkg;

  // Default configuration.
  localparam int MOD_WIDTH_DEF  = 32;
  localparam int MAX_LEVELS_DEF = 64;

  // Fixed field widths.
  localparam int BASE_W   = 64;
  localparam int HEIGHT_W = 64;
  localparam int MODF_W   = 32;
  localparam int RESULT_W = 32;
  localparam int DIV_W    = 64;

  // Controller states.
  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_BUILD, S_TLOOP, S_TDIV1, S_TDT, S_TDIVT, S_TWH, S_TDIVW,
    S_TTDIV, S_STORE, S_LDIV, S_UNW, S_MI, S_PSTART, S_PXDIV, S_PSTEP, S_VCHK,
    S_VDIV, S_PSHIFT, S_XMUL, S_XCHK, S_XDIV, S_ADD, S_ADD2, S_FDIV, S_OUT
  } state_t;

  // Datapath operations.
  typedef enum logic [4:0] {
    OP_NONE, OP_SPECIAL, OP_CHAIN0, OP_TOT_INIT, OP_DIV_VP, OP_DIV_TP, OP_DIV_TV,
    OP_DIV_AC, OP_DIV_AMI, OP_DIV_PROD, OP_DIV_VAL, OP_SET_V_Q, OP_P_INC,
    OP_MUL_T_QP, OP_MUL_T_QV, OP_STORE, OP_LEAF1, OP_LEAF_ADD, OP_UNW_DEC,
    OP_MI_LOAD, OP_PW_ONE, OP_PW_XINIT, OP_MUL_V, OP_MUL_X, OP_V_PROD, OP_V_REM,
    OP_X_PROD, OP_X_REM, OP_E_SHIFT, OP_MUL_CM, OP_VAL_ADD, OP_RES_REM
  } op_t;

  typedef struct packed {
    logic ready;
    op_t  op;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic rem_zero;
    logic special;
    logic chain_go;
    logic cur_one;
    logic psq_le;
    logic tv_gt1;
    logic val_zero;
    logic e_odd;
    logic e_last;
    logic prod_ge;
    logic k_zero;
    logic out_free;
  } stat_t;

endpackage

// File: sv/tm_div.sv
`include "assert_macros.svh"

module tm_div import tm_pkg::*; #(
  parameter int MOD_WIDTH = MOD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_W-1:0]     dividend,
  input  logic [MOD_WIDTH-1:0] divisor,
  output logic                 done,
  output logic [DIV_W-1:0]     quo,
  output logic [MOD_WIDTH-1:0] rem
);

  localparam int SW = $clog2(DIV_W + 1);

  logic [SW-1:0]        steps;
  logic [MOD_WIDTH-1:0] dvs;
  logic [MOD_WIDTH:0]   sh;
  logic [MOD_WIDTH:0]   diff;
  logic                 ge;

  // One quotient bit per cycle, restoring form.
  assign sh   = {rem, quo[DIV_W-1]};
  assign ge   = sh >= {1'b0, dvs};
  assign diff = sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        steps <= SW'(DIV_W);
        quo   <= dividend;
        rem   <= '0;
        dvs   <= divisor;
      end else if (steps != '0) begin
        rem   <= ge ? diff[MOD_WIDTH-1:0] : sh[MOD_WIDTH-1:0];
        quo   <= {quo[DIV_W-2:0], ge};
        steps <= steps - SW'(1);
        if (steps == SW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  `TM_ASSERT_NXT(a_start_busy, start, steps == SW'(DIV_W))
  `TM_ASSERT_IMP(a_done_idle, done, steps == '0)
  `TM_ASSERT_NXT(a_step_count, (steps != '0) && !start, steps == $past(steps) - SW'(1))

endmodule

// File: sv/tm_ctrl.sv
module tm_ctrl import tm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_CHECK;
      S_CHECK:  state_next = stat.special ? S_OUT : S_BUILD;
      S_BUILD: begin
        if (stat.chain_go) state_next = S_TLOOP;
        else if (stat.cur_one) state_next = S_UNW;
        else state_next = S_LDIV;
      end
      S_TLOOP: begin
        if (stat.psq_le) state_next = S_TDIV1;
        else if (stat.tv_gt1) state_next = S_TTDIV;
        else state_next = S_STORE;
      end
      S_TDIV1:  if (stat.div_done) state_next = stat.rem_zero ? S_TDT : S_TLOOP;
      S_TDT:    state_next = S_TDIVT;
      S_TDIVT:  if (stat.div_done) state_next = S_TWH;
      S_TWH:    state_next = S_TDIVW;
      S_TDIVW:  if (stat.div_done) state_next = stat.rem_zero ? S_TWH : S_TLOOP;
      S_TTDIV:  if (stat.div_done) state_next = S_STORE;
      S_STORE:  state_next = S_BUILD;
      S_LDIV:   if (stat.div_done) state_next = S_UNW;
      S_UNW:    state_next = stat.k_zero ? S_FDIV : S_MI;
      S_MI:     state_next = S_PSTART;
      S_PSTART: state_next = stat.val_zero ? S_ADD : S_PXDIV;
      S_PXDIV:  if (stat.div_done) state_next = S_PSTEP;
      S_PSTEP:  state_next = stat.e_odd ? S_VCHK : S_PSHIFT;
      S_VCHK:   state_next = stat.prod_ge ? S_VDIV : S_PSHIFT;
      S_VDIV:   if (stat.div_done) state_next = S_PSHIFT;
      S_PSHIFT: state_next = stat.e_last ? S_ADD : S_XMUL;
      S_XMUL:   state_next = S_XCHK;
      S_XCHK:   state_next = stat.prod_ge ? S_XDIV : S_PSTEP;
      S_XDIV:   if (stat.div_done) state_next = S_PSTEP;
      S_ADD:    state_next = S_ADD2;
      S_ADD2:   state_next = S_UNW;
      S_FDIV:   if (stat.div_done) state_next = S_OUT;
      S_OUT:    if (stat.out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd.ready    = 1'b0;
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    case (state)
      S_IDLE:   cmd.ready = 1'b1;
      S_CHECK:  cmd.op = stat.special ? OP_SPECIAL : OP_CHAIN0;
      S_BUILD: begin
        if (stat.chain_go) cmd.op = OP_TOT_INIT;
        else if (stat.cur_one) cmd.op = OP_LEAF1;
        else cmd.op = OP_DIV_AC;
      end
      S_TLOOP: begin
        if (stat.psq_le) cmd.op = OP_DIV_VP;
        else if (stat.tv_gt1) cmd.op = OP_DIV_TV;
      end
      S_TDIV1:  if (stat.div_done) cmd.op = stat.rem_zero ? OP_SET_V_Q : OP_P_INC;
      S_TDT:    cmd.op = OP_DIV_TP;
      S_TDIVT:  if (stat.div_done) cmd.op = OP_MUL_T_QP;
      S_TWH:    cmd.op = OP_DIV_VP;
      S_TDIVW:  if (stat.div_done) cmd.op = stat.rem_zero ? OP_SET_V_Q : OP_P_INC;
      S_TTDIV:  if (stat.div_done) cmd.op = OP_MUL_T_QV;
      S_STORE:  cmd.op = OP_STORE;
      S_LDIV:   if (stat.div_done) cmd.op = OP_LEAF_ADD;
      S_UNW:    cmd.op = stat.k_zero ? OP_DIV_VAL : OP_UNW_DEC;
      S_MI:     cmd.op = OP_MI_LOAD;
      S_PSTART: cmd.op = stat.val_zero ? OP_PW_ONE : OP_DIV_AMI;
      S_PXDIV:  if (stat.div_done) cmd.op = OP_PW_XINIT;
      S_PSTEP:  if (stat.e_odd) cmd.op = OP_MUL_V;
      S_VCHK:   cmd.op = stat.prod_ge ? OP_DIV_PROD : OP_V_PROD;
      S_VDIV:   if (stat.div_done) cmd.op = OP_V_REM;
      S_PSHIFT: cmd.op = OP_E_SHIFT;
      S_XMUL:   cmd.op = OP_MUL_X;
      S_XCHK:   cmd.op = stat.prod_ge ? OP_DIV_PROD : OP_X_PROD;
      S_XDIV:   if (stat.div_done) cmd.op = OP_X_REM;
      S_ADD:    cmd.op = OP_MUL_CM;
      S_ADD2:   cmd.op = OP_VAL_ADD;
      S_FDIV:   if (stat.div_done) cmd.op = OP_RES_REM;
      S_OUT:    cmd.out_load = stat.out_free;
      default:  cmd.op = OP_NONE;
    endcase
  end

endmodule

// File: sv/tm_datapath.sv
module tm_datapath import tm_pkg::*; #(
  parameter int MOD_WIDTH  = MOD_WIDTH_DEF,
  parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output stat_t               stat,
  input  logic                in_valid,
  input  logic [BASE_W-1:0]   in_base,
  input  logic [HEIGHT_W-1:0] in_height,
  input  logic [MODF_W-1:0]   in_modulus,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [RESULT_W-1:0] out_result
);

  localparam int MW  = MOD_WIDTH;
  localparam int KW  = $clog2(MAX_LEVELS);
  localparam int CW  = $clog2(MAX_LEVELS + 2);
  localparam int PW  = 2 * MOD_WIDTH;
  localparam int SQW = MOD_WIDTH + 2;

  logic [BASE_W-1:0]   a;
  logic [HEIGHT_W-1:0] n;
  logic [MW-1:0]       m, cur, tv, tt, p, mi, pv, px, res;
  logic [SQW-1:0]      psq;
  logic [KW-1:0]       k;
  logic [DIV_W-1:0]    val, e;
  logic [CW-1:0]       cnt;
  logic [PW-1:0]       prod;

  // Modulus chain store and its port signals.
  logic [MW-1:0] chain [MAX_LEVELS];
  logic [MW-1:0] rdata, wdata;
  logic [KW-1:0] waddr;
  logic          wen;

  logic             div_start, div_done;
  logic [DIV_W-1:0] div_dividend, div_quo;
  logic [MW-1:0]    div_divisor, div_rem;

  logic [MW-1:0] mul_a, mul_b;
  logic [PW-1:0] mul_p;
  logic          leaf_cnt;

  tm_div #(.MOD_WIDTH(MOD_WIDTH)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // Shared multiplier; its product always lands in a register.
  assign mul_p = {{MW{1'b0}}, mul_a} * {{MW{1'b0}}, mul_b};

  // Remaining tower over a modulus of one is zero only for base zero with odd height.
  assign leaf_cnt = (a != '0) || !(n[0] ^ k[0]);

  // Operand selection for the divider, multiplier and chain store.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    mul_a        = '0;
    mul_b        = '0;
    wen          = 1'b0;
    waddr        = '0;
    wdata        = tt;
    case (cmd.op)
      OP_DIV_VP: begin
        div_start = 1'b1; div_dividend = DIV_W'(tv); div_divisor = p;
      end
      OP_DIV_TP: begin
        div_start = 1'b1; div_dividend = DIV_W'(tt); div_divisor = p;
      end
      OP_DIV_TV: begin
        div_start = 1'b1; div_dividend = DIV_W'(tt); div_divisor = tv;
      end
      OP_DIV_AC: begin
        div_start = 1'b1; div_dividend = a; div_divisor = cur;
      end
      OP_DIV_AMI: begin
        div_start = 1'b1; div_dividend = a; div_divisor = mi;
      end
      OP_DIV_PROD: begin
        div_start = 1'b1; div_dividend = DIV_W'(prod); div_divisor = mi;
      end
      OP_DIV_VAL: begin
        div_start = 1'b1; div_dividend = val; div_divisor = m;
      end
      OP_MUL_T_QP: begin
        mul_a = div_quo[MW-1:0]; mul_b = p - MW'(1);
      end
      OP_MUL_T_QV: begin
        mul_a = div_quo[MW-1:0]; mul_b = tv - MW'(1);
      end
      OP_MUL_V: begin
        mul_a = pv; mul_b = px;
      end
      OP_MUL_X: begin
        mul_a = px; mul_b = px;
      end
      OP_MUL_CM: begin
        mul_a = MW'(cnt); mul_b = mi;
      end
      OP_CHAIN0: begin
        wen = 1'b1; waddr = '0; wdata = m;
      end
      OP_STORE: begin
        wen = 1'b1; waddr = k + KW'(1); wdata = tt;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Chain memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wen) begin
      chain[waddr] <= wdata;
    end
    rdata <= chain[k - KW'(1)];
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.ready && in_valid) begin
      a <= in_base;
      n <= in_height;
      m <= in_modulus[MW-1:0];
    end
    case (cmd.op)
      OP_SPECIAL:  res <= MW'((m > MW'(1)) && ((a == BASE_W'(1)) || (n == '0)));
      OP_CHAIN0: begin
        cur <= m;
        k   <= '0;
      end
      OP_TOT_INIT: begin
        tv  <= cur;
        tt  <= cur;
        p   <= MW'(2);
        psq <= SQW'(4);
      end
      OP_SET_V_Q:  tv <= div_quo[MW-1:0];
      OP_P_INC: begin
        p   <= p + MW'(1);
        psq <= psq + {1'b0, p, 1'b1};
      end
      OP_MUL_T_QP: tt <= mul_p[MW-1:0];
      OP_MUL_T_QV: tt <= mul_p[MW-1:0];
      OP_STORE: begin
        k   <= k + KW'(1);
        cur <= tt;
      end
      OP_LEAF1: begin
        cnt <= CW'(leaf_cnt);
        val <= DIV_W'(leaf_cnt);
      end
      OP_DIV_AC:   cnt <= CW'(a >= BASE_W'(cur));
      OP_LEAF_ADD: val <= DIV_W'(div_rem) + ((cnt != '0) ? DIV_W'(cur) : '0);
      OP_UNW_DEC:  k <= k - KW'(1);
      OP_MI_LOAD:  mi <= rdata;
      OP_PW_ONE:   pv <= MW'(1);
      OP_DIV_AMI:  cnt <= cnt + CW'(a >= BASE_W'(mi));
      OP_PW_XINIT: begin
        px <= div_rem;
        pv <= MW'(1);
        e  <= val;
      end
      OP_MUL_V:    prod <= mul_p;
      OP_MUL_X:    prod <= mul_p;
      OP_MUL_CM:   prod <= mul_p;
      OP_DIV_PROD: cnt <= CW'(1);
      OP_V_PROD:   pv <= prod[MW-1:0];
      OP_V_REM:    pv <= div_rem;
      OP_X_PROD:   px <= prod[MW-1:0];
      OP_X_REM:    px <= div_rem;
      OP_E_SHIFT:  e <= e >> 1;
      OP_VAL_ADD:  val <= DIV_W'(prod) + DIV_W'(pv);
      OP_RES_REM:  res <= div_rem;
      default:     res <= res;
    endcase
  end

  // Output register; a waiting result does not hold up the input side.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid  <= 1'b1;
      out_result <= RESULT_W'(res);
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Status to the controller.
  always_comb begin
    stat.div_done = div_done;
    stat.rem_zero = div_rem == '0;
    stat.special  = (m <= MW'(1)) || (a == BASE_W'(1)) || (n == '0);
    stat.chain_go = (cur != MW'(1)) && ((n - HEIGHT_W'(k)) > HEIGHT_W'(1))
                    && (((KW+1)'(k) + (KW+1)'(1)) < (KW+1)'(MAX_LEVELS));
    stat.cur_one  = cur == MW'(1);
    stat.psq_le   = psq <= SQW'(tv);
    stat.tv_gt1   = tv > MW'(1);
    stat.val_zero = val == '0;
    stat.e_odd    = e[0];
    stat.e_last   = e[DIV_W-1:1] == '0;
    stat.prod_ge  = prod >= PW'(mi);
    stat.k_zero   = k == '0;
    stat.out_free = !out_valid || out_ready;
  end

endmodule

// File: sv/tetration_modulo_top.sv
// Channel  | Direction | Contents of tdata, lowest bit first
// s_axis   | in        | base[63:0], height[127:64], modulus[159:128]
// m_axis   | out       | result[31:0]
//
// Each transaction runs alone: the modulus chain is built by trial division up to
// the square root, every trial step costing at least one pass of the shared divider
// (a start, 64 quotient bits and a done strobe).
// Unwinding costs per level about log2(exponent) multiply and reduce steps, each
// reduction again a divider pass.
// Synchronous active-high reset; no clearing pass, the chain store is written before use.
// A finished result waits in the output register while the next transaction is accepted.
`include "assert_macros.svh"

module tetration_modulo_top import tm_pkg::*; #(
  parameter int MOD_WIDTH  = MOD_WIDTH_DEF,
  parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [159:0] s_tdata,   // base[63:0], height[127:64], modulus[159:128]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata    // result[31:0]
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencing of the chain build and unwind.
  tm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Registers, chain store, divider and multiplier.
  tm_datapath #(
    .MOD_WIDTH  (MOD_WIDTH),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_valid   (s_tvalid),
    .in_base    (s_tdata[63:0]),
    .in_height  (s_tdata[127:64]),
    .in_modulus (s_tdata[159:128]),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_result (m_tdata)
  );

  assign s_tready = cmd.ready;

  `TM_ASSERT_NXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)

endmodule

// File: tb/sv/tetration_modulo_checker.sv
// Watches both channels of the tetration block, predicts each result from the
// accepted input transaction and compares it with what the block returns.
module tetration_modulo_checker import tm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [159:0] s_tdata,   // base[63:0], height[127:64], modulus[159:128]
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [31:0]  m_tdata,   // result[31:0]
  output int           errors,
  output int           pending,
  output int           results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHAIN_DEPTH = MAX_LEVELS_DEF;

  logic [RESULT_W-1:0] expected_results[$];

  // Euler totient by trial division up to the square root.
  function automatic longint unsigned euler_phi(input longint unsigned v);
    longint unsigned t;
    longint unsigned p;
    t = v;
    for (p = 2; p * p <= v; p++) begin
      if (v % p == 0) begin
        t = t / p * (p - 1);
        while (v % p == 0) v = v / p;
      end
    end
    if (v > 1) t = t / v * (v - 1);
    return t;
  endfunction

  // Square-and-multiply modulo m, marking every value that reached m.
  function automatic longint unsigned marked_pow(input longint unsigned a,
                                                 input longint unsigned e,
                                                 input longint unsigned m,
                                                 inout longint unsigned wraps);
    longint unsigned v;
    longint unsigned x;
    v = 1;
    x = a;
    if (a == 1 || e == 0) return 1;
    if (x >= m) wraps++;
    x = x % m;
    forever begin
      if (e[0]) v = v * x;
      if (v >= m) begin
        wraps = 1;
        v = v % m;
      end
      e = e >> 1;
      if (e == 0) break;
      x = x * x;
      if (x >= m) begin
        wraps = 1;
        x = x % m;
      end
    end
    return v;
  endfunction

  // Power tower of the given height modulo the modulus.
  function automatic logic [RESULT_W-1:0] tower_mod(input logic [BASE_W-1:0] a,
                                                    input logic [HEIGHT_W-1:0] n,
                                                    input logic [MODF_W-1:0] mod_in);
    longint unsigned chain[CHAIN_DEPTH];
    longint unsigned m;
    longint unsigned wraps;
    longint unsigned val;
    longint unsigned mk;
    longint unsigned rem;
    int k;
    m = mod_in;
    wraps = 0;
    k = 0;
    if (m == 0) return '0;
    if (a == 1) return RESULT_W'(1 % m);
    if (m == 1) return '0;
    if (n == 0) return 1;
    chain[0] = m;
    while (chain[k] != 1 && n - 64'(k) > 1 && k + 1 < CHAIN_DEPTH) begin
      chain[k + 1] = euler_phi(chain[k]);
      k++;
    end
    mk = chain[k];
    rem = n - 64'(k);
    if (mk == 1) begin
      // The rest of the tower is zero only for base zero with an odd height left.
      wraps = (a != 0 || rem[0] == 1'b0) ? 1 : 0;
      val = wraps;
    end else begin
      wraps = (a >= mk) ? 1 : 0;
      val = a % mk + wraps * mk;
    end
    for (int i = k - 1; i >= 0; i--) begin
      val = marked_pow(a, val, chain[i], wraps) + wraps * chain[i];
    end
    return RESULT_W'(val % m);
  endfunction

  assign pending = expected_results.size();

  // Predict on every input transaction, compare on every output transaction.
  always @(posedge clk) begin
    logic [RESULT_W-1:0] want;
    if (rst) begin
      errors <= 0;
      results_seen <= 0;
      expected_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          if (errors < 10) $display("unexpected result %0d with nothing pending", m_tdata);
          errors <= errors + 1;
        end else begin
          want = expected_results.pop_front();
          if (want !== m_tdata) begin
            if (errors < 10) $display("result mismatch: expected %0d, got %0d", want, m_tdata);
            errors <= errors + 1;
          end
        end
      end
      if (s_tvalid && s_tready)
        expected_results.push_back(tower_mod(s_tdata[63:0], s_tdata[127:64],
                                             s_tdata[159:128]));
    end
  end

endmodule

// File: tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 200_000_000;
  localparam int RANDOM_ITEMS = 80;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [159:0] s_tdata;   // base[63:0], height[127:64], modulus[159:128]
  logic         m_tvalid;
  logic         m_tready;
  logic [31:0]  m_tdata;   // result[31:0]
  int           errors;
  int           pending;
  int           results_seen;
  longint       cycles = 0;
  bit           steady;
  int           sent;

  tetration_modulo_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  tetration_modulo_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .errors(errors), .pending(pending), .results_seen(results_seen)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // The receiver stalls about a fifth of the time, except in the steady stretch.
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= steady || ($urandom_range(99) >= 21);
  end

  // Offers one transaction, possibly after a few idle cycles, and waits for it.
  task automatic send_item(input logic [63:0] base, input logic [63:0] height,
                           input logic [31:0] modulus);
    if (!steady && $urandom_range(99) < 21) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {modulus, height, base};
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  initial begin
    logic [63:0] b;
    logic [63:0] h;
    logic [31:0] m;
    steady = 1'b0;
    sent = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes and every special case.
    send_item(64'd1, 64'd5, 32'd1000);               // base one
    send_item(64'd1, 64'd5, 32'd1);                  // base one, modulus one
    send_item(64'd7, 64'd9, 32'd1);                  // modulus one
    send_item(64'd7, 64'd0, 32'd1000);               // height zero
    send_item(64'd3, 64'd2, 32'd0);                  // modulus zero
    send_item(64'd0, 64'd3, 32'd2);                  // base zero, even height left
    send_item(64'd0, 64'd4, 32'd2);                  // base zero, odd height left
    send_item(64'd0, 64'd1, 32'd10);
    send_item(64'd0, 64'd2, 32'd10);
    send_item(64'd2, 64'd1, 32'd97);
    send_item(64'd2, 64'd3, 32'd100);
    send_item(64'd2, 64'd4, 32'd1000);
    send_item(64'd3, 64'd3, 32'd1000);
    send_item('1, 64'd1, 32'd97);
    send_item('1, '1, 32'd1000);
    send_item(64'd2, '1, 32'd12);
    send_item(64'd5, 64'd6, 32'hFFFF_FFFF);
    send_item(64'd3, 64'd4, 32'h8000_0000);
    send_item('1, '1, 32'hFFFF_FFFF);
    send_item(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 32'd1024);
    send_item(64'd10, 64'd3, 32'd10);

    // Let everything drain before the random part.
    s_tvalid <= 1'b0;
    wait (pending == 0);
    @(posedge clk);

    // Random: mostly small moduli keep the trial division short.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady = (i >= 40 && i < 60);
      case ($urandom_range(9))
        0: b = 64'($urandom_range(1));
        1, 2, 3: b = {$urandom, $urandom};
        default: b = 64'($urandom_range(2, 50));
      endcase
      case ($urandom_range(9))
        0: h = {$urandom, $urandom};
        1: h = 64'($urandom_range(0, 2));
        default: h = 64'($urandom_range(1, 40));
      endcase
      if ($urandom_range(19) == 0) m = 32'($urandom_range(2, 65535));
      else m = 32'($urandom_range(1, 1023));
      send_item(b, h, m);
    end
    steady = 1'b0;
    s_tvalid <= 1'b0;

    wait (pending == 0);
    repeat (200) @(posedge clk);
    $display("Sent %0d towers (directed extremes and special cases, then random),", sent);
    $display("checked %0d results against the prediction.", results_seen);
    if (errors == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/tm_pkg.sv
sv/tm_div.sv
sv/tm_ctrl.sv
sv/tm_datapath.sv
sv/tetration_modulo_top.sv
tb/sv/tetration_modulo_checker.sv
tb/sv/testbench.sv
